FILE: rtl/core/tcaga_pkg.sv
// Shared constants, command and status types of the two-class grant arbiter.
package tcaga_pkg;

  localparam int unsigned ID_WIDTH    = 8;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned GRANT_W     = 8;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic STATUS_GRANT = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;     // capture the accepted input item
    logic grant_now;     // grant the captured requester, resource was free
    logic push;          // append the captured ID to its category queue
    logic drop;          // report the captured request as dropped
    logic release_free;  // mark the resource free
    logic pop;           // read and remove the head of queue pop_cat
    logic pop_cat;       // queue selected for pop
    logic pop_emit;      // present the popped ID as a grant
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       kind;
    logic       cat;
    logic       holder_free;
    logic       holder_cat;
    logic [1:0] q_nonempty;
    logic [1:0] q_full;
    logic       out_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/tcaga_datapath.sv
// Datapath: item registers, holder register, two ID queues and the result register.
module tcaga_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tcaga_pkg::ctl_cmd_t                   cmd,
  output tcaga_pkg::dp_status_t                 stat,
  input  logic                                  in_kind,
  input  logic                                  in_category,
  input  logic [tcaga_pkg::ID_WIDTH-1:0]        in_requester_id,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_status,
  output logic [tcaga_pkg::GRANT_W-1:0]         out_grant_id,
  output logic                                  out_grant_category
);

  localparam int unsigned IDW   = tcaga_pkg::ID_WIDTH;
  localparam int unsigned DEPTH = tcaga_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = tcaga_pkg::PTR_W;
  localparam int unsigned CW    = tcaga_pkg::CNT_W;
  localparam int unsigned GW    = tcaga_pkg::GRANT_W;

  // Captured item
  logic           kind_r, cat_r;
  logic [IDW-1:0] id_r;

  // Holder
  logic holder_free_r, holder_free_nxt;
  logic holder_cat_r, holder_cat_nxt;

  // Queue pointers, one set per category
  logic [PW-1:0] head_r  [0:1];
  logic [PW-1:0] head_nxt[0:1];
  logic [CW-1:0] cnt_r   [0:1];
  logic [CW-1:0] cnt_nxt [0:1];
  logic [PW-1:0] tail    [0:1];
  logic [PW:0]   tail_sum[0:1];

  // Queue storage and registered read data
  logic [IDW-1:0] q0_mem_r [0:DEPTH-1];
  logic [IDW-1:0] q1_mem_r [0:DEPTH-1];
  logic [IDW-1:0] q0_rd_r, q1_rd_r;
  logic           pop_cat_r;
  logic [IDW-1:0] pop_id;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r;
  logic [GW-1:0] out_id_r;
  logic          out_cat_r;
  logic          out_load;
  logic          out_status_nxt;
  logic [IDW-1:0] out_src_id;
  logic          out_cat_nxt;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      cat_r  <= in_category;
      id_r   <= in_requester_id;
    end
  end

  // Compute tail positions with wrap at the queue depth
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      tail_sum[c] = {1'b0, head_r[c]} + cnt_r[c][PW:0];
      if (tail_sum[c] >= (PW+1)'(DEPTH)) begin
        tail[c] = PW'(tail_sum[c] - (PW+1)'(DEPTH));
      end else begin
        tail[c] = tail_sum[c][PW-1:0];
      end
    end
  end

  // Advance head and count on push and pop
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      head_nxt[c] = head_r[c];
      cnt_nxt[c]  = cnt_r[c];
      if (cmd.push && (cat_r == 1'(c))) begin
        cnt_nxt[c] = cnt_r[c] + CW'(1);
      end
      if (cmd.pop && (cmd.pop_cat == 1'(c))) begin
        cnt_nxt[c] = cnt_r[c] - CW'(1);
        if (head_r[c] == PW'(DEPTH - 1)) begin
          head_nxt[c] = '0;
        end else begin
          head_nxt[c] = head_r[c] + PW'(1);
        end
      end
    end
  end

  // Update holder
  always_comb begin
    holder_free_nxt = holder_free_r;
    holder_cat_nxt  = holder_cat_r;
    if (cmd.grant_now) begin
      holder_free_nxt = 1'b0;
      holder_cat_nxt  = cat_r;
    end
    if (cmd.pop) begin
      holder_cat_nxt = cmd.pop_cat;
    end
    if (cmd.release_free) begin
      holder_free_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holder_free_r <= 1'b1;
      holder_cat_r  <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        head_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
    end else begin
      holder_free_r <= holder_free_nxt;
      holder_cat_r  <= holder_cat_nxt;
      for (int c = 0; c < 2; c++) begin
        head_r[c] <= head_nxt[c];
        cnt_r[c]  <= cnt_nxt[c];
      end
    end
  end

  // Queue zero storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.push && !cat_r) begin
      q0_mem_r[tail[0]] <= id_r;
    end
    if (cmd.pop && !cmd.pop_cat) begin
      q0_rd_r <= q0_mem_r[head_r[0]];
    end
  end

  // Queue one storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.push && cat_r) begin
      q1_mem_r[tail[1]] <= id_r;
    end
    if (cmd.pop && cmd.pop_cat) begin
      q1_rd_r <= q1_mem_r[head_r[1]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pop_cat_r <= cmd.pop_cat;
    end
  end

  assign pop_id = pop_cat_r ? q1_rd_r : q0_rd_r;

  // Select the result source
  always_comb begin
    out_load       = cmd.grant_now || cmd.drop || cmd.pop_emit;
    out_status_nxt = cmd.drop ? tcaga_pkg::STATUS_DROP : tcaga_pkg::STATUS_GRANT;
    out_src_id     = cmd.pop_emit ? pop_id : id_r;
    out_cat_nxt    = cmd.pop_emit ? pop_cat_r : cat_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= GW'(out_src_id);
      out_cat_r    <= out_cat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_grant_id       = out_id_r;
  assign out_grant_category = out_cat_r;

  // Status to the controller
  always_comb begin
    stat.kind        = kind_r;
    stat.cat         = cat_r;
    stat.holder_free = holder_free_r;
    stat.holder_cat  = holder_cat_r;
    for (int c = 0; c < 2; c++) begin
      stat.q_nonempty[c] = (cnt_r[c] != '0);
      stat.q_full[c]     = (cnt_r[c] == CW'(DEPTH));
    end
    stat.out_busy = out_valid_r && !out_ready;
  end

`ifndef ASSERT_OFF
  a_cnt0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(DEPTH)) else $error("queue zero count above depth");
  a_cnt1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[1] <= CW'(DEPTH)) else $error("queue one count above depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.q_full[cat_r]) else $error("push into full queue");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> stat.q_nonempty[cmd.pop_cat]) else $error("pop from empty queue");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !stat.out_busy) else $error("result overwritten before taken");
`endif

endmodule

FILE: rtl/core/tcaga_ctrl.sv
// Controller: sequences accept, decision, queue read and result load for each item.
module tcaga_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcaga_pkg::dp_status_t stat,
  output tcaga_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   other_cat;
  logic   own_cat;

  assign own_cat   = stat.holder_cat;
  assign other_cat = ~stat.holder_cat;
  assign in_ready  = (state_r == ST_IDLE);

  // Decide the action for the captured item
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.kind == tcaga_pkg::KIND_REQUEST) begin
          if (stat.holder_free) begin
            if (!stat.out_busy) begin
              cmd.grant_now = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end else if (stat.q_full[stat.cat]) begin
            if (!stat.out_busy) begin
              cmd.drop  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.push  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (stat.holder_free) begin
            state_nxt = ST_IDLE;
          end else if (stat.q_nonempty[other_cat] || stat.q_nonempty[own_cat]) begin
            // Hand over: other category first, then own
            if (!stat.out_busy) begin
              cmd.pop     = 1'b1;
              cmd.pop_cat = stat.q_nonempty[other_cat] ? other_cat : own_cat;
              state_nxt   = ST_POP;
            end
          end else begin
            cmd.release_free = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        cmd.pop_emit = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pop_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> cmd.pop_emit) else $error("popped ID not presented");
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> (state_r == ST_EXEC)) else $error("accepted item not decided");
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.grant_now, cmd.push, cmd.drop, cmd.release_free, cmd.pop}))
    else $error("several actions at once");
`endif

endmodule

FILE: rtl/core/two_class_alternating_grant_arbiter_unit.sv
// Two-class grant arbiter top level: joins the controller and the datapath.
// One resource is shared by requesters of category 0 and 1, each with a
// 16-entry FIFO of waiting IDs. A request on a free resource is granted at
// once; on a busy one it is queued, or dropped with status 1 when its queue
// is full. A release hands the resource to the head of the other category's
// queue first, then to the own category's, else frees it. Items are handled
// one at a time: a request or a release that frees or is ignored passes
// through the accept and decide steps; a release that hands over adds a
// step for the registered read of the queue memory. An item that produces a
// result waits in the decide step while the previous result has not been
// taken. The block accepts its next item while its last result still waits.
module two_class_alternating_grant_arbiter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic                                in_category,
  input  logic [tcaga_pkg::ID_WIDTH-1:0]      in_requester_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_status,
  output logic [tcaga_pkg::GRANT_W-1:0]       out_grant_id,
  output logic                                out_grant_category
);

  tcaga_pkg::ctl_cmd_t   cmd;
  tcaga_pkg::dp_status_t stat;

  // Sequence each item
  tcaga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold holder, queues and result
  tcaga_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_category        (in_category),
    .in_requester_id    (in_requester_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_grant_id       (out_grant_id),
    .out_grant_category (out_grant_category)
  );

endmodule
